@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ rtl/trwt_pkg.sv @@
// ----------------------------------------------------------------------------
// trwt_pkg
// types, codes and defaults for the tcp receive window table
// ----------------------------------------------------------------------------
package trwt_pkg;

    localparam int SESSIONS_DEF = 1024;
    localparam int WIN_BITS_DEF = 16;
    // wide enough to compare any session against the largest table size
    localparam int SESS_EXT_W   = 17;

    localparam logic [2:0] FUNC_WIN_QUERY = 3'd0;
    localparam logic [2:0] FUNC_APP_WRITE = 3'd1;
    localparam logic [2:0] FUNC_APP_READ  = 3'd2;
    localparam logic [2:0] FUNC_RX_WRITE  = 3'd3;
    localparam logic [2:0] FUNC_RX_READ   = 3'd4;

    localparam logic [1:0] KIND_WINDOW = 2'd0;
    localparam logic [1:0] KIND_APP    = 2'd1;
    localparam logic [1:0] KIND_RX     = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [9:0]  session;
        logic [31:0] recvd_in;
        logic [15:0] appd_in;
        logic [31:0] head_in;
        logic [31:0] offset_in;
        logic        gap_in;
        logic        init_in;
        logic [3:0]  shift_in;
    } t_request;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  session_out;
        logic [31:0] recvd_out;
        logic [15:0] appd_out;
        logic [31:0] head_out;
        logic [31:0] offset_out;
        logic        gap_out;
        logic [3:0]  shift_out;
        logic [15:0] window_size;
    } t_result;

    // fields written together by the receive engine
    typedef struct packed {
        logic [31:0] recvd;
        logic [31:0] head;
        logic [31:0] offset;
        logic        gap;
    } t_entry;

endpackage

@@ rtl/trwt_ram.sv @@
// ----------------------------------------------------------------------------
// trwt_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module trwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns the old word on a same-edge write
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tcp_receive_window_table.sv @@
// ----------------------------------------------------------------------------
// tcp_receive_window_table
// per-session tcp receive state table with window query
// a result item passes the registered table read, then the output register
// throughput: one item per cycle while i_rsp_stall does not hold the output, set by the single registered table read
// writes land in the table at the accept edge, so the next item sees them
// reset clears control and scale_enable; table contents are kept, and an
// entry read before its init write returns undefined fields
// ----------------------------------------------------------------------------
module tcp_receive_window_table
    import trwt_pkg::*;
#(
    parameter int SESSIONS = SESSIONS_DEF,
    parameter int WIN_BITS = WIN_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  logic     i_req_valid,
    output logic     o_req_stall,
    input  t_request i_req,
    output logic     o_rsp_valid,
    input  logic     i_rsp_stall,
    output t_result  o_rsp
);

    localparam int ADDR_W = $clog2(SESSIONS);

    logic r_scale_enable;

    // stage 1: table read in flight
    logic        r_s1_valid, n_s1_valid;
    logic [1:0]  r_s1_kind;
    logic [9:0]  r_s1_session;
    logic        r_s1_ok;

    logic        r_out_valid;
    t_result     r_rsp, n_rsp;

    logic                  accept, out_free, s1_free, s1_adv;
    logic [SESS_EXT_W-1:0] sess_ext;
    logic                  sess_ok, has_result;
    logic [1:0]            req_kind;
    logic [ADDR_W-1:0]     addr;

    logic                  we_ent, we_appd, we_shift;
    t_entry                wd_ent, rd_ent, ent;
    logic [15:0]           wd_appd, rd_appd, appd;
    logic [3:0]            rd_shift, shift;

    logic [WIN_BITS-1:0]   w_full, w_scaled;
    logic [15:0]           w_plain, window;

    assign out_free    = !r_out_valid || !i_rsp_stall;
    assign s1_adv      = r_s1_valid && out_free;
    assign s1_free     = !r_s1_valid || out_free;
    assign o_req_stall = !s1_free;
    assign accept      = i_req_valid && s1_free;

    assign sess_ext = SESS_EXT_W'(i_req.session);
    assign sess_ok  = sess_ext < SESS_EXT_W'(SESSIONS);
    assign addr     = sess_ext[ADDR_W-1:0];

    always_comb begin
        has_result = 1'b0;
        req_kind   = KIND_WINDOW;
        case (i_req.func)
            FUNC_WIN_QUERY: begin
                has_result = 1'b1;
                req_kind   = KIND_WINDOW;
            end
            FUNC_APP_READ: begin
                has_result = 1'b1;
                req_kind   = KIND_APP;
            end
            FUNC_RX_READ: begin
                has_result = 1'b1;
                req_kind   = KIND_RX;
            end
            default: begin
                has_result = 1'b0;
                req_kind   = KIND_WINDOW;
            end
        endcase
    end

    // table writes
    assign we_ent   = accept && sess_ok && (i_req.func == FUNC_RX_WRITE);
    assign we_shift = we_ent && i_req.init_in;
    assign we_appd  = (accept && sess_ok && (i_req.func == FUNC_APP_WRITE)) || we_shift;
    assign wd_appd  = (i_req.func == FUNC_APP_WRITE) ? i_req.appd_in : i_req.recvd_in[15:0];

    assign wd_ent.recvd  = i_req.recvd_in;
    assign wd_ent.head   = i_req.head_in;
    assign wd_ent.offset = i_req.offset_in;
    assign wd_ent.gap    = i_req.gap_in;

    trwt_ram #(.WIDTH($bits(t_entry)), .DEPTH(SESSIONS)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (we_ent),
        .i_waddr (addr),
        .i_wdata (wd_ent),
        .i_re    (accept),
        .i_raddr (addr),
        .o_rdata (rd_ent)
    );

    trwt_ram #(.WIDTH(16), .DEPTH(SESSIONS)) u_appd_ram (
        .i_clk   (i_clk),
        .i_we    (we_appd),
        .i_waddr (addr),
        .i_wdata (wd_appd),
        .i_re    (accept),
        .i_raddr (addr),
        .o_rdata (rd_appd)
    );

    trwt_ram #(.WIDTH(4), .DEPTH(SESSIONS)) u_shift_ram (
        .i_clk   (i_clk),
        .i_we    (we_shift),
        .i_waddr (addr),
        .i_wdata (i_req.shift_in),
        .i_re    (accept),
        .i_raddr (addr),
        .o_rdata (rd_shift)
    );

    // out-of-range sessions read as an all-zero entry
    assign ent   = r_s1_ok ? rd_ent   : '0;
    assign appd  = r_s1_ok ? rd_appd  : '0;
    assign shift = r_s1_ok ? rd_shift : '0;

    assign w_full   = WIN_BITS'(appd) - ent.recvd[WIN_BITS-1:0] - WIN_BITS'(1);
    assign w_scaled = w_full >> shift;
    assign w_plain  = appd - ent.recvd[15:0] - 16'd1;
    assign window   = r_scale_enable ? w_scaled[15:0] : w_plain;

    always_comb begin
        n_rsp             = '0;
        n_rsp.kind        = r_s1_kind;
        n_rsp.session_out = r_s1_session;
        case (r_s1_kind)
            KIND_WINDOW: begin
                n_rsp.recvd_out   = ent.recvd;
                n_rsp.appd_out    = appd;
                n_rsp.head_out    = ent.head;
                n_rsp.offset_out  = ent.offset;
                n_rsp.gap_out     = ent.gap;
                n_rsp.shift_out   = shift;
                n_rsp.window_size = window;
            end
            KIND_APP: begin
                n_rsp.appd_out = appd;
            end
            KIND_RX: begin
                n_rsp.recvd_out  = ent.recvd;
                n_rsp.appd_out   = appd;
                n_rsp.head_out   = ent.head;
                n_rsp.offset_out = ent.offset;
                n_rsp.gap_out    = ent.gap;
                n_rsp.shift_out  = shift;
            end
            default: begin
                n_rsp.appd_out = '0;
            end
        endcase
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = has_result;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_enable <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_scale_enable <= i_cfg_wdata;
            end
            r_s1_valid <= n_s1_valid;
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind    <= req_kind;
            r_s1_session <= i_req.session;
            r_s1_ok      <= sess_ok;
        end
        if (s1_adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

@@ rtl/trwt_checker.sv @@
// ----------------------------------------------------------------------------
// trwt_checker
// port-level checks on the tcp receive window table results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trwt_checker
    import trwt_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_rsp_valid,
    input logic    i_rsp_stall,
    input t_result o_rsp
);

    logic rsp_wait;
    logic app_clean;

    assign rsp_wait  = o_rsp_valid && i_rsp_stall;
    // every field but the kind, the session and the pointer is zero
    assign app_clean = (o_rsp.recvd_out == 32'd0) && (o_rsp.head_out == 32'd0)
        && (o_rsp.offset_out == 32'd0) && !o_rsp.gap_out && (o_rsp.shift_out == 4'd0)
        && (o_rsp.window_size == 16'd0);

    // reset empties the result register on the next edge
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_rsp_valid)

    // a waiting result item is held until taken
    `ASSERT_CLK(a_rsp_hold, i_clk, i_rst_n, rsp_wait |=> o_rsp_valid && $stable(o_rsp))

    // app replies carry the session and the pointer and nothing else
    `ASSERT_CLK(a_app_only_appd, i_clk, i_rst_n, o_rsp_valid && (o_rsp.kind == KIND_APP) |-> app_clean)

    // rx replies carry no window
    `ASSERT_CLK(a_rx_no_window, i_clk, i_rst_n, o_rsp_valid && (o_rsp.kind == KIND_RX) |-> o_rsp.window_size == 16'd0)

endmodule

bind tcp_receive_window_table trwt_checker u_trwt_checker (.*);
